// ===== src/gda_pkg.sv =====
// Shared types, constants and the microcode program of the date adder.
package gda_pkg;

  // Operation kinds carried on in_kind
  localparam logic [2:0] KIND_DAYS   = 3'd0;
  localparam logic [2:0] KIND_WEEKS  = 3'd1;
  localparam logic [2:0] KIND_MONTHS = 3'd2;
  localparam logic [2:0] KIND_YEARS  = 3'd3;
  localparam logic [2:0] KIND_DECADE = 3'd4;
  localparam logic [2:0] KIND_CENT   = 3'd5;
  localparam logic [2:0] KIND_MILL   = 3'd6;
  localparam logic [2:0] KIND_NONE   = 3'd7;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_DEC = 4'd12;

  // Reciprocal of 25 scaled by 2^17, rounded down; quotient is exact or one low
  localparam logic [12:0] RECIP25    = 13'd5242;
  localparam int          RECIP_SHFT = 17;

  localparam logic [18:0] ADD_CENT = 19'd100;
  localparam logic [18:0] ADD_MILL = 19'd1000;

  localparam int UPC_W = 5;
  localparam int CNT_W = 18;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,
    OP_LEAP,
    OP_CHK,
    OP_LDCNT,
    OP_DAY,
    OP_MON,
    OP_YADD,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOREQ,
    C_BAD,
    C_KADD,
    C_KMON,
    C_KNOP,
    C_DSTAY,
    C_MSTAY,
    C_CNTZ,
    C_OBUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] tgt;
  } ctl_t;

  // Program addresses
  localparam logic [UPC_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [UPC_W-1:0] ST_LMUL  = 5'd1;
  localparam logic [UPC_W-1:0] ST_LREM  = 5'd2;
  localparam logic [UPC_W-1:0] ST_CHECK = 5'd3;
  localparam logic [UPC_W-1:0] ST_LDCNT = 5'd4;
  localparam logic [UPC_W-1:0] ST_KMON  = 5'd5;
  localparam logic [UPC_W-1:0] ST_KNOP  = 5'd6;
  localparam logic [UPC_W-1:0] ST_DSTEP = 5'd7;
  localparam logic [UPC_W-1:0] ST_DEND  = 5'd8;
  localparam logic [UPC_W-1:0] ST_DMUL  = 5'd9;
  localparam logic [UPC_W-1:0] ST_DREM  = 5'd10;
  localparam logic [UPC_W-1:0] ST_MSTEP = 5'd11;
  localparam logic [UPC_W-1:0] ST_MEND  = 5'd12;
  localparam logic [UPC_W-1:0] ST_MMUL  = 5'd13;
  localparam logic [UPC_W-1:0] ST_MREM  = 5'd14;
  localparam logic [UPC_W-1:0] ST_YADD  = 5'd15;
  localparam logic [UPC_W-1:0] ST_DONE  = 5'd16;
  localparam logic [UPC_W-1:0] ST_OUT   = 5'd17;
  localparam logic [UPC_W-1:0] ST_LAST  = ST_OUT;

  function automatic ctl_t ucode(input logic [UPC_W-1:0] a);
    ctl_t w;
    unique case (a)
      ST_IDLE:  w = '{OP_NOP,   C_NOREQ,  ST_IDLE};
      ST_LMUL:  w = '{OP_MUL,   C_NEVER,  ST_IDLE};
      ST_LREM:  w = '{OP_LEAP,  C_NEVER,  ST_IDLE};
      ST_CHECK: w = '{OP_CHK,   C_BAD,    ST_DONE};
      ST_LDCNT: w = '{OP_LDCNT, C_KADD,   ST_YADD};
      ST_KMON:  w = '{OP_NOP,   C_KMON,   ST_MSTEP};
      ST_KNOP:  w = '{OP_NOP,   C_KNOP,   ST_DONE};
      ST_DSTEP: w = '{OP_DAY,   C_DSTAY,  ST_DSTEP};
      ST_DEND:  w = '{OP_NOP,   C_CNTZ,   ST_DONE};
      ST_DMUL:  w = '{OP_MUL,   C_NEVER,  ST_IDLE};
      ST_DREM:  w = '{OP_LEAP,  C_ALWAYS, ST_DSTEP};
      ST_MSTEP: w = '{OP_MON,   C_MSTAY,  ST_MSTEP};
      ST_MEND:  w = '{OP_NOP,   C_CNTZ,   ST_DONE};
      ST_MMUL:  w = '{OP_MUL,   C_NEVER,  ST_IDLE};
      ST_MREM:  w = '{OP_LEAP,  C_ALWAYS, ST_MSTEP};
      ST_YADD:  w = '{OP_YADD,  C_ALWAYS, ST_DONE};
      ST_DONE:  w = '{OP_NOP,   C_OBUSY,  ST_DONE};
      ST_OUT:   w = '{OP_OUT,   C_ALWAYS, ST_IDLE};
      default:  w = '{OP_NOP,   C_ALWAYS, ST_IDLE};
    endcase
    return w;
  endfunction

  // Month length; zero for a month code outside January..December
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MON_FEB:                                    len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== src/gregorian_date_adder_unit.sv =====
// Gregorian date adder: microcoded sequencer stepping days or months one per cycle, pausing at year rolls.
//
//   channel | direction | ports                                     | handshake
//   --------+-----------+-------------------------------------------+-----------------
//   in      | input     | in_kind in_count in_day in_month in_year  | in_valid/in_stall
//   out     | output    | out_day out_month out_year                | out_valid/out_stall
//           |           | out_year_wrapped out_bad_date             |
//
// Flow: one request at a time. Days/weeks take n steps, n = count or 7 * count, and
//   each December-to-January roll before the last step adds a leap flag refresh
//   through the one multiplier. Months step count times with the same refresh per year
//   roll. Year-type kinds add to the year directly; the unused kind and an invalid
//   date skip the stepping. The single-unit day/month step sets the rate.
// Reset: rst_n (synchronous, low) parks the program counter at idle and empties
//   the output register.
// Stalls: the result sits in an output register, so a new request is taken while
//   the previous result is still stalled; the program waits only at its done step.
module gregorian_date_adder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [14:0] in_count,
  input  logic [4:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [15:0] in_year,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [15:0] out_year,
  output logic        out_year_wrapped,
  output logic        out_bad_date
);
  import gda_pkg::*;

  // Sequencer
  logic [UPC_W-1:0] upc_r, upc_nxt;
  ctl_t             ctl;
  logic             jump;

  // Working date and control registers
  logic [2:0]       kind_r, kind_nxt;
  logic [14:0]      count_r, count_nxt;
  logic [4:0]       day_r, day_nxt;
  logic [3:0]       mon_r, mon_nxt;
  logic [15:0]      year_r, year_nxt;
  logic             wrap_r, wrap_nxt;
  logic             bad_r, bad_nxt;
  logic             leap_r, leap_nxt;
  logic [28:0]      prod_r, prod_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Output register
  logic             ovld_r, ovld_nxt;
  logic [4:0]       oday_r, oday_nxt;
  logic [3:0]       omon_r, omon_nxt;
  logic [15:0]      oyear_r, oyear_nxt;
  logic             owrap_r, owrap_nxt;
  logic             obad_r, obad_nxt;

  // Datapath helpers
  logic             in_fire;
  logic [4:0]       cur_len;
  logic [4:0]       next_len;
  logic [3:0]       mon_inc;
  logic [11:0]      quo25;
  logic [15:0]      q25;
  logic [15:0]      rem_raw;
  logic [15:0]      rem25;
  logic             div25;
  logic             cnt_nz;
  logic             day_roll;
  logic             year_roll;
  logic [18:0]      add_amt;
  logic [18:0]      ysum;

  assign in_stall = (upc_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign ctl      = ucode(upc_r);

  assign cur_len   = days_in(mon_r, leap_r);
  assign mon_inc   = mon_r + 4'd1;
  assign next_len  = days_in(mon_inc, leap_r);
  assign cnt_nz    = (cnt_r != '0);
  assign day_roll  = (day_r == cur_len);
  assign year_roll = (mon_r == MON_DEC);

  // y mod 25 from the registered reciprocal product, one corrective subtract
  assign quo25   = prod_r[28:RECIP_SHFT];
  assign q25     = {quo25, 4'b0} + {1'b0, quo25, 3'b0} + {4'b0, quo25};
  assign rem_raw = year_r - q25;
  assign rem25   = (rem_raw >= 16'd25) ? (rem_raw - 16'd25) : rem_raw;
  assign div25   = (rem25 == 16'd0);

  always_comb begin
    case (kind_r)
      KIND_YEARS:  add_amt = {4'b0, count_r};
      KIND_DECADE: add_amt = {1'b0, count_r, 3'b0} + {3'b0, count_r, 1'b0};
      KIND_CENT:   add_amt = ADD_CENT;
      default:     add_amt = ADD_MILL;
    endcase
    ysum = {3'b0, year_r} + add_amt;
  end

  // Jump condition select
  always_comb begin
    unique case (ctl.cond)
      C_NEVER:  jump = 1'b0;
      C_ALWAYS: jump = 1'b1;
      C_NOREQ:  jump = !in_valid;
      C_BAD:    jump = bad_nxt;
      C_KADD:   jump = (kind_r == KIND_YEARS) || (kind_r == KIND_DECADE) ||
                       (kind_r == KIND_CENT)  || (kind_r == KIND_MILL);
      C_KMON:   jump = (kind_r == KIND_MONTHS);
      C_KNOP:   jump = (kind_r == KIND_NONE);
      C_DSTAY:  jump = cnt_nz && !(day_roll && year_roll);
      C_MSTAY:  jump = cnt_nz && !year_roll;
      C_CNTZ:   jump = !cnt_nz;
      C_OBUSY:  jump = ovld_r && out_stall;
      default:  jump = 1'b0;
    endcase
    upc_nxt = jump ? ctl.tgt : (upc_r + 5'd1);
  end

  // Datapath
  always_comb begin
    kind_nxt  = kind_r;
    count_nxt = count_r;
    day_nxt   = day_r;
    mon_nxt   = mon_r;
    year_nxt  = year_r;
    wrap_nxt  = wrap_r;
    bad_nxt   = bad_r;
    leap_nxt  = leap_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    oday_nxt  = oday_r;
    omon_nxt  = omon_r;
    oyear_nxt = oyear_r;
    owrap_nxt = owrap_r;
    obad_nxt  = obad_r;
    ovld_nxt  = ovld_r && out_stall;

    if (in_fire) begin
      kind_nxt  = in_kind;
      count_nxt = in_count;
      day_nxt   = in_day;
      mon_nxt   = in_month;
      year_nxt  = in_year;
      wrap_nxt  = 1'b0;
      bad_nxt   = 1'b0;
    end

    case (ctl.op)
      OP_MUL: begin
        prod_nxt = 29'(year_r) * 29'(RECIP25);
      end
      OP_LEAP: begin
        leap_nxt = ((year_r[1:0] == 2'b00) && !div25) || ((year_r[3:0] == 4'h0) && div25);
      end
      OP_CHK: begin
        bad_nxt = (mon_r < MON_JAN) || (mon_r > MON_DEC) ||
                  (day_r == 5'd0) || (day_r > cur_len);
      end
      OP_LDCNT: begin
        if (kind_r == KIND_WEEKS) begin
          cnt_nxt = {count_r, 3'b0} - {3'b0, count_r};
        end else begin
          cnt_nxt = {3'b0, count_r};
        end
      end
      OP_DAY: begin
        if (cnt_nz) begin
          cnt_nxt = cnt_r - 18'd1;
          if (day_roll) begin
            day_nxt = 5'd1;
            if (year_roll) begin
              mon_nxt  = MON_JAN;
              year_nxt = year_r + 16'd1;
              if (year_r == 16'hFFFF) begin
                wrap_nxt = 1'b1;
              end
            end else begin
              mon_nxt = mon_inc;
            end
          end else begin
            day_nxt = day_r + 5'd1;
          end
        end
      end
      OP_MON: begin
        if (cnt_nz) begin
          cnt_nxt = cnt_r - 18'd1;
          if (year_roll) begin
            // January is 31 days long: no clamp
            mon_nxt  = MON_JAN;
            year_nxt = year_r + 16'd1;
            if (year_r == 16'hFFFF) begin
              wrap_nxt = 1'b1;
            end
          end else begin
            mon_nxt = mon_inc;
            if (day_r > next_len) begin
              day_nxt = next_len;
            end
          end
        end
      end
      OP_YADD: begin
        year_nxt = ysum[15:0];
        if (ysum[18:16] != 3'b000) begin
          wrap_nxt = 1'b1;
        end
      end
      OP_OUT: begin
        ovld_nxt  = 1'b1;
        oday_nxt  = day_r;
        omon_nxt  = mon_r;
        oyear_nxt = year_r;
        owrap_nxt = wrap_r;
        obad_nxt  = bad_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= ST_IDLE;
      ovld_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    count_r <= count_nxt;
    day_r   <= day_nxt;
    mon_r   <= mon_nxt;
    year_r  <= year_nxt;
    wrap_r  <= wrap_nxt;
    bad_r   <= bad_nxt;
    leap_r  <= leap_nxt;
    prod_r  <= prod_nxt;
    cnt_r   <= cnt_nxt;
    oday_r  <= oday_nxt;
    omon_r  <= omon_nxt;
    oyear_r <= oyear_nxt;
    owrap_r <= owrap_nxt;
    obad_r  <= obad_nxt;
  end

  assign out_valid        = ovld_r;
  assign out_day          = oday_r;
  assign out_month        = omon_r;
  assign out_year         = oyear_r;
  assign out_year_wrapped = owrap_r;
  assign out_bad_date     = obad_r;

  // Program counter stays inside the program
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r <= ST_LAST)
    else $error("microcode address out of range");

  // A new result appears only from the output step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(upc_r == ST_OUT))
    else $error("result loaded outside output step");

  // A flagged bad date never reports a wrap
  a_bad_nowrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_bad_date && out_year_wrapped))
    else $error("bad date with wrap flag");

  // Each day step consumes exactly one unit
  a_day_count: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == ST_DSTEP && cnt_r != '0) |=> (cnt_r == $past(cnt_r) - 18'd1))
    else $error("day step counter slip");

  // Valid results carry a legal month
  a_out_month: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bad_date) |-> (out_month >= MON_JAN && out_month <= MON_DEC))
    else $error("result month out of range");

endmodule
